// File: rtl/core/vitc_pkg.sv
// Package for the virtual-lane input buffer credit tracker.
// Holds field widths, command, event, fault and register codes and the item structs.
// No dependencies; every other file of the block imports it.
package vitc_pkg;

    localparam int LANE_W     = 2;
    localparam int CNT_W      = 16;
    localparam int FLIT_W     = 8;
    localparam int PCRED_W    = 8;
    localparam int LID_W      = 16;
    localparam int ROUTE_W    = 7;
    localparam int PORT_W     = 6;
    localparam int NPORT_W    = 7;
    localparam int CRED_W     = 12;
    localparam int DROP_W     = 32;
    localparam int NUM_STATIC = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;
    localparam int S_TDATA_W  = 112;
    localparam int M_TDATA_W  = 80;

    localparam logic [CRED_W-1:0]  STATIC_CRED_RST = 12'd64;
    localparam logic [NPORT_W-1:0] NUM_PORTS_RST   = 7'd1;

    typedef enum logic [1:0] {
        CMD_FLOW_CTRL = 2'd0,
        CMD_DATA      = 2'd1,
        CMD_CRED_RET  = 2'd2,
        CMD_RSVD      = 2'd3
    } cmd_e_t;

    typedef enum logic [2:0] {
        EV_FC_DONE  = 3'd0,
        EV_QUEUED   = 3'd1,
        EV_DROPPED  = 3'd2,
        EV_CRED_RET = 3'd3,
        EV_ERROR    = 3'd4
    } event_e_t;

    typedef enum logic [2:0] {
        FAULT_NONE       = 3'd0,
        FAULT_OVERFLOW   = 3'd1,
        FAULT_UNEXPECTED = 3'd2,
        FAULT_CRED_LEAK  = 3'd3,
        FAULT_LANE_RANGE = 3'd4,
        FAULT_ZERO_DLID  = 3'd5,
        FAULT_LOOPBACK   = 3'd6
    } fault_e_t;

    typedef enum logic [2:0] {
        REG_LOSSY_MODE    = 3'd0,
        REG_ENDPOINT_MODE = 3'd1,
        REG_NUM_PORTS     = 3'd2,
        REG_THIS_PORT     = 3'd3,
        REG_STATIC_CRED0  = 3'd4,
        REG_STATIC_CRED1  = 3'd5,
        REG_STATIC_CRED2  = 3'd6,
        REG_STATIC_CRED3  = 3'd7
    } cfg_reg_e_t;

    typedef struct packed {
        cmd_e_t                    command;
        logic [LANE_W-1:0]         lane;
        logic [CNT_W-1:0]          sender_total_blocks;
        logic [CNT_W-1:0]          partner_credit_limit;
        logic [FLIT_W-1:0]         flit_number;
        logic [PCRED_W-1:0]        packet_credits;
        logic [LID_W-1:0]          packet_tag;
        logic [LID_W-1:0]          source_lid;
        logic [LID_W-1:0]          dest_lid;
        logic signed [ROUTE_W-1:0] route_port;
        logic                      before_switch;
    } in_item_t;

    typedef struct packed {
        event_e_t          event_res;
        fault_e_t          fault;
        logic              ahead_warning;
        logic              rx_credit_valid;
        logic [LANE_W-1:0] rx_credit_lane;
        logic [CNT_W-1:0]  rx_credit_limit;
        logic              tx_credit_valid;
        logic [CNT_W-1:0]  tx_credit_limit;
        logic [PORT_W-1:0] queue_port;
        logic [LANE_W-1:0] queue_lane;
        logic [DROP_W-1:0] dropped_total;
    } out_item_t;

    typedef struct packed {
        logic                                lossy_mode;
        logic                                endpoint_mode;
        logic [NPORT_W-1:0]                  num_ports;
        logic [PORT_W-1:0]                   this_port;
        logic [NUM_STATIC-1:0][CRED_W-1:0]   static_cred;
    } cfg_t;

endpackage

// File: rtl/core/vitc_cfg.sv
// Configuration register file of the credit tracker.
// Depends on vitc_pkg for register codes, widths and the cfg_t struct.
module vitc_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [vitc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [vitc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output vitc_pkg::cfg_t                   cfg
);
    import vitc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_LOSSY_MODE:    cfg_next.lossy_mode     = cfg_wdata[0];
                REG_ENDPOINT_MODE: cfg_next.endpoint_mode  = cfg_wdata[0];
                REG_NUM_PORTS:     cfg_next.num_ports      = cfg_wdata[NPORT_W-1:0];
                REG_THIS_PORT:     cfg_next.this_port      = cfg_wdata[PORT_W-1:0];
                REG_STATIC_CRED0:  cfg_next.static_cred[0] = cfg_wdata[CRED_W-1:0];
                REG_STATIC_CRED1:  cfg_next.static_cred[1] = cfg_wdata[CRED_W-1:0];
                REG_STATIC_CRED2:  cfg_next.static_cred[2] = cfg_wdata[CRED_W-1:0];
                REG_STATIC_CRED3:  cfg_next.static_cred[3] = cfg_wdata[CRED_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lossy_mode    <= 1'b0;
            cfg_reg.endpoint_mode <= 1'b0;
            cfg_reg.num_ports     <= NUM_PORTS_RST;
            cfg_reg.this_port     <= '0;
            for (int i = 0; i < NUM_STATIC; i++) begin
                cfg_reg.static_cred[i] <= STATIC_CRED_RST;
            end
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/vitc_proc.sv
// Per-lane credit state and the single-pass decision logic for one item.
// Depends on vitc_pkg; driven by the input register of the top level.
module vitc_proc #(
    parameter int NUM_LANES = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                proc_en,
    input  vitc_pkg::in_item_t  item,
    input  vitc_pkg::cfg_t      cfg,
    output vitc_pkg::out_item_t res
);
    import vitc_pkg::*;

    logic [CNT_W-1:0]  rcv_blk_reg   [NUM_LANES];
    logic [CNT_W-1:0]  rcv_blk_next  [NUM_LANES];
    logic [CRED_W-1:0] free_cred_reg [NUM_LANES];
    logic [CRED_W-1:0] free_cred_next[NUM_LANES];

    logic [LID_W-1:0]          cur_tag_reg,  cur_tag_next;
    logic [LID_W-1:0]          cur_src_reg,  cur_src_next;
    logic [LANE_W-1:0]         cur_lane_reg, cur_lane_next;
    logic signed [ROUTE_W-1:0] cur_port_reg, cur_port_next;
    logic [DROP_W-1:0]         drop_cnt_reg, drop_cnt_next;

    logic [LANE_W-1:0]         el;
    logic                      ln_ok;
    logic [CNT_W-1:0]          sel_rb;
    logic [CRED_W-1:0]         sel_free;
    logic [CRED_W-1:0]         sel_static;
    logic [CNT_W-1:0]          rb_new;
    logic [CRED_W-1:0]         free_new;
    logic                      wr_lane;
    logic                      data_go;
    logic                      first_go;
    logic signed [ROUTE_W-1:0] port_pick;
    logic signed [ROUTE_W-1:0] eff_port;
    logic                      drop_en;
    logic [PCRED_W-1:0]        drop_amt;
    logic [DROP_W:0]           drop_sum;
    logic [CRED_W-1:0]         lim_add;

    always_comb begin
        el = (item.command == CMD_DATA && item.flit_number != '0) ? cur_lane_reg : item.lane;
        ln_ok = {1'b0, item.lane} < (LANE_W + 1)'(NUM_LANES);
        sel_rb   = '0;
        sel_free = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            if (el == LANE_W'(i)) begin
                sel_rb   = rcv_blk_reg[i];
                sel_free = free_cred_reg[i];
            end
        end
        sel_static = cfg.static_cred[el];

        res           = '0;
        res.event_res = EV_ERROR;
        res.fault     = FAULT_NONE;
        rb_new        = sel_rb;
        free_new      = sel_free;
        wr_lane       = 1'b0;
        data_go       = 1'b0;
        first_go      = 1'b1;
        port_pick     = '0;
        eff_port      = cur_port_reg;
        drop_en       = 1'b0;
        drop_amt      = '0;
        cur_tag_next  = cur_tag_reg;
        cur_src_next  = cur_src_reg;
        cur_lane_next = cur_lane_reg;
        cur_port_next = cur_port_reg;

        case (item.command)
            CMD_FLOW_CTRL: begin
                if (!ln_ok) begin
                    res.fault = FAULT_LANE_RANGE;
                end else begin
                    res.event_res       = EV_FC_DONE;
                    res.tx_credit_valid = 1'b1;
                    res.tx_credit_limit = item.partner_credit_limit;
                    if (sel_rb > item.sender_total_blocks) begin
                        res.ahead_warning = 1'b1;
                    end else begin
                        rb_new = item.sender_total_blocks;
                    end
                    wr_lane             = 1'b1;
                    res.rx_credit_valid = 1'b1;
                    res.rx_credit_lane  = el;
                end
            end
            CMD_DATA: begin
                if (item.flit_number == '0) begin
                    if (item.dest_lid == '0) begin
                        res.fault = FAULT_ZERO_DLID;
                    end else if (!ln_ok) begin
                        res.fault = FAULT_LANE_RANGE;
                    end else if (CRED_W'(item.packet_credits) > sel_free) begin
                        if (!cfg.lossy_mode) begin
                            res.fault = FAULT_OVERFLOW;
                        end else begin
                            cur_tag_next  = item.packet_tag;
                            cur_src_next  = item.source_lid;
                            cur_lane_next = item.lane;
                            cur_port_next = '1;
                            drop_en       = 1'b1;
                            drop_amt      = item.packet_credits;
                            res.event_res = EV_DROPPED;
                        end
                    end else begin
                        if (cfg.num_ports > NPORT_W'(1) && !cfg.endpoint_mode) begin
                            port_pick = item.route_port;
                            if (!item.before_switch &&
                                item.route_port == {1'b0, cfg.this_port}) begin
                                res.fault = FAULT_LOOPBACK;
                                first_go  = 1'b0;
                            end
                        end
                        if (first_go) begin
                            cur_tag_next  = item.packet_tag;
                            cur_src_next  = item.source_lid;
                            cur_lane_next = item.lane;
                            cur_port_next = port_pick[ROUTE_W-1] ? '1 : port_pick;
                            eff_port      = port_pick;
                            data_go       = 1'b1;
                        end
                    end
                end else if (item.packet_tag != cur_tag_reg ||
                             item.source_lid != cur_src_reg) begin
                    res.fault = FAULT_UNEXPECTED;
                end else begin
                    data_go = 1'b1;
                end
                if (data_go) begin
                    if (eff_port[ROUTE_W-1] || NPORT_W'(eff_port) >= cfg.num_ports) begin
                        res.event_res = EV_DROPPED;
                    end else if (sel_free == '0) begin
                        if (!cfg.lossy_mode) begin
                            res.fault = FAULT_OVERFLOW;
                        end else begin
                            drop_en       = 1'b1;
                            drop_amt      = PCRED_W'(1);
                            res.event_res = EV_DROPPED;
                        end
                    end else begin
                        free_new            = sel_free - CRED_W'(1);
                        rb_new              = sel_rb + CNT_W'(1);
                        wr_lane             = 1'b1;
                        res.event_res       = EV_QUEUED;
                        res.rx_credit_valid = 1'b1;
                        res.rx_credit_lane  = el;
                        res.queue_port      = eff_port[PORT_W-1:0];
                        res.queue_lane      = el;
                    end
                end
            end
            CMD_CRED_RET: begin
                if (!ln_ok) begin
                    res.fault = FAULT_LANE_RANGE;
                end else if (sel_free < sel_static) begin
                    free_new            = sel_free + CRED_W'(1);
                    wr_lane             = 1'b1;
                    res.event_res       = EV_CRED_RET;
                    res.rx_credit_valid = 1'b1;
                    res.rx_credit_lane  = el;
                end else begin
                    res.fault = FAULT_CRED_LEAK;
                end
            end
            default: begin
                res.event_res = EV_ERROR;
                res.fault     = FAULT_NONE;
            end
        endcase

        lim_add = cfg.lossy_mode ? sel_static : free_new;
        if (res.rx_credit_valid) begin
            res.rx_credit_limit = rb_new + CNT_W'(lim_add);
        end

        drop_sum      = {1'b0, drop_cnt_reg} + (DROP_W + 1)'(drop_amt);
        drop_cnt_next = drop_cnt_reg;
        if (drop_en) begin
            drop_cnt_next = drop_sum[DROP_W] ? '1 : drop_sum[DROP_W-1:0];
        end
        res.dropped_total = drop_cnt_next;

        for (int i = 0; i < NUM_LANES; i++) begin
            rcv_blk_next[i]   = rcv_blk_reg[i];
            free_cred_next[i] = free_cred_reg[i];
            if (wr_lane && el == LANE_W'(i)) begin
                rcv_blk_next[i]   = rb_new;
                free_cred_next[i] = free_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                rcv_blk_reg[i]   <= '0;
                free_cred_reg[i] <= STATIC_CRED_RST;
            end
            cur_tag_reg  <= '0;
            cur_src_reg  <= '0;
            cur_lane_reg <= '0;
            cur_port_reg <= '1;
            drop_cnt_reg <= '0;
        end else if (proc_en) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                rcv_blk_reg[i]   <= rcv_blk_next[i];
                free_cred_reg[i] <= free_cred_next[i];
            end
            cur_tag_reg  <= cur_tag_next;
            cur_src_reg  <= cur_src_next;
            cur_lane_reg <= cur_lane_next;
            cur_port_reg <= cur_port_next;
            drop_cnt_reg <= drop_cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_drop_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> drop_cnt_reg >= $past(drop_cnt_reg))
        else $error("Dropped credit count went down.");

    a_latched_lane_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, cur_lane_reg} < (LANE_W + 1)'(NUM_LANES))
        else $error("Latched packet lane is out of range.");
`endif

endmodule

// File: rtl/core/vl_input_buffer_credit_tracker.sv
// Top level of the virtual-lane input buffer credit tracker.
// Depends on vitc_pkg, vitc_cfg and vitc_proc.
//
// The block is the receive side of per-lane credit flow control. Each item on
// the s_ channel is a flow-control packet, a data flit or a credit return,
// selected by s_tuser. Each item yields exactly one result on the m_ channel,
// whose kind of event travels in m_tuser; tdata carries the fault code, the
// new receive credit limit, the forwarded partner limit, the queue target and
// the running dropped-credit total.
// An item sits in the input register, where the lane counters are read and
// updated in the same cycle, and then waits in the output register; m_tvalid
// rises once it reaches the output register. One item is accepted per cycle
// for as long as the receiver takes results, since the per-lane counter update
// is a single step. When m_tready is low the output register holds its result,
// the input register still takes one more item, and s_tready then drops until
// the result is taken. Reset clears both valid flags, sets all lane counters
// to their reset values and loads the configuration registers with their
// defaults. Configuration writes take effect on the next edge; the user makes
// them while the block is idle, and the block itself does not enforce this.
module vl_input_buffer_credit_tracker #(
    parameter int NUM_LANES = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // lane, sender_total_blocks, partner_credit_limit, flit_number,
    // packet_credits, packet_tag, source_lid, dest_lid, route_port,
    // before_switch, zero fill
    input  logic [vitc_pkg::S_TDATA_W-1:0]   s_tdata,
    // command
    input  logic [1:0]                       s_tuser,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // fault, ahead_warning, rx_credit_valid, rx_credit_lane, rx_credit_limit,
    // tx_credit_valid, tx_credit_limit, queue_port, queue_lane, dropped_total
    output logic [vitc_pkg::M_TDATA_W-1:0]   m_tdata,
    // event_res
    output logic [2:0]                       m_tuser,

    input  logic                             cfg_wr_en,
    input  logic [vitc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [vitc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import vitc_pkg::*;

    cfg_t      cfg;
    in_item_t  in_item_reg,  in_item_next;
    logic      in_valid_reg, in_valid_next;
    out_item_t out_item_reg, res;
    logic      m_valid_reg,  m_valid_next;
    logic      out_ready;
    logic      proc_en;
    logic      s_fire;

    vitc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    vitc_proc #(
        .NUM_LANES (NUM_LANES)
    ) u_proc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .proc_en (proc_en),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    assign out_ready = !m_valid_reg || m_tready;
    assign proc_en   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign s_fire    = s_tvalid && s_tready;

    always_comb begin
        in_item_next.command              = cmd_e_t'(s_tuser);
        in_item_next.lane                 = s_tdata[1:0];
        in_item_next.sender_total_blocks  = s_tdata[17:2];
        in_item_next.partner_credit_limit = s_tdata[33:18];
        in_item_next.flit_number          = s_tdata[41:34];
        in_item_next.packet_credits       = s_tdata[49:42];
        in_item_next.packet_tag           = s_tdata[65:50];
        in_item_next.source_lid           = s_tdata[81:66];
        in_item_next.dest_lid             = s_tdata[97:82];
        in_item_next.route_port           = s_tdata[104:98];
        in_item_next.before_switch        = s_tdata[105];

        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (proc_en) begin
            in_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (proc_en) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= in_item_next;
        end
        if (proc_en) begin
            out_item_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_item_reg.event_res;
    assign m_tdata  = {out_item_reg.dropped_total,
                       out_item_reg.queue_lane,
                       out_item_reg.queue_port,
                       out_item_reg.tx_credit_limit,
                       out_item_reg.tx_credit_valid,
                       out_item_reg.rx_credit_limit,
                       out_item_reg.rx_credit_lane,
                       out_item_reg.rx_credit_valid,
                       out_item_reg.ahead_warning,
                       out_item_reg.fault};

`ifndef SYNTHESIS
    a_proc_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_en |=> m_valid_reg)
        else $error("A processed item left no result.");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_ready |-> !s_tready)
        else $error("Input register could be overwritten while stalled.");

    a_fault_only_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_item_reg.fault == FAULT_NONE ||
                         out_item_reg.event_res == EV_ERROR))
        else $error("Fault code set on a result that is not an error.");

    a_credit_report_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_item_reg.rx_credit_valid |->
            (out_item_reg.event_res == EV_FC_DONE ||
             out_item_reg.event_res == EV_QUEUED ||
             out_item_reg.event_res == EV_CRED_RET))
        else $error("Credit limit reported on a result that changes no credits.");
`endif

endmodule
